FILE: design/ttlcd_pkg.sv
// ----------------------------------------------------------------------------
// ttlcd_pkg
// Shared types, constants and color lookup table for the temperature trend
// LED color dimmer.
// ----------------------------------------------------------------------------
package ttlcd_pkg;

  // LED pin bits
  localparam logic [2:0] ColorR = 3'b001;
  localparam logic [2:0] ColorG = 3'b010;
  localparam logic [2:0] ColorB = 3'b100;

  localparam int unsigned IdxW = 5;
  localparam logic [IdxW-1:0] LastIndex = 5'd19;
  localparam logic [IdxW-1:0] HomeIndex = 5'd8;

  localparam int unsigned IntervalW = 12;
  localparam int unsigned WeakOnW   = 8;
  localparam int unsigned DimCntW   = 16;
  localparam int unsigned OffW      = 4;
  localparam int unsigned CfgDataW  = 12;

  localparam logic [IntervalW-1:0] IntervalReset = 12'd1200;
  localparam logic [WeakOnW-1:0]   WeakOnReset   = 8'd1;

  typedef enum logic {
    CFG_SAMPLE_INTERVAL = 1'b0,
    CFG_WEAK_ON         = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]      strong_col;
    logic [2:0]      weak_col;
    logic [OffW-1:0] off;
  } color_entry_t;

  // Color table; indexes past the last entry read the last entry.
  function automatic color_entry_t color_rom(input logic [IdxW-1:0] idx);
    color_entry_t e;
    unique case (idx)
      5'd0:    e = '{ColorR,          3'b000, 4'd0};
      5'd1:    e = '{ColorR,          ColorG, 4'd9};
      5'd2:    e = '{ColorR,          ColorG, 4'd3};
      5'd3:    e = '{ColorR,          ColorG, 4'd1};
      5'd4:    e = '{ColorR | ColorG, 3'b000, 4'd0};
      5'd5:    e = '{ColorG,          ColorR, 4'd1};
      5'd6:    e = '{ColorG,          ColorR, 4'd3};
      5'd7:    e = '{ColorG,          ColorR, 4'd9};
      5'd8:    e = '{ColorG,          3'b000, 4'd0};
      5'd9:    e = '{ColorG,          ColorB, 4'd9};
      5'd10:   e = '{ColorG,          ColorB, 4'd3};
      5'd11:   e = '{ColorG,          ColorB, 4'd1};
      5'd12:   e = '{ColorG | ColorB, 3'b000, 4'd0};
      5'd13:   e = '{ColorB,          ColorG, 4'd1};
      5'd14:   e = '{ColorB,          ColorG, 4'd3};
      5'd15:   e = '{ColorB,          ColorG, 4'd9};
      5'd16:   e = '{ColorB,          3'b000, 4'd0};
      5'd17:   e = '{ColorB,          ColorR, 4'd9};
      5'd18:   e = '{ColorB,          ColorR, 4'd3};
      default: e = '{ColorB,          ColorR, 4'd1};
    endcase
    return e;
  endfunction

endpackage

FILE: design/temperature_trend_led_color_dimmer_top.sv
// ----------------------------------------------------------------------------
// temperature_trend_led_color_dimmer_top
// One scheduler tick per input transfer: tracks the temperature trend against
// a reference, picks a strong/weak LED color pair and PWM-dims the weak color.
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, button_pressed_i,         | in
//          | sample_valid_i, sample_i                         |
//  out     | out_valid_o/out_ready_i, led_bits_o,             | out
//          | start_conversion_o                               |
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i                | in
//
// One tick per cycle: the tick's state update and result are computed in the
// accepting cycle and appear in the result register on the next cycle.
// One tick per cycle unless out_ready_i stalls the single result register.
// in_ready_o is high while the result register is empty or being drained.
// Reset clears all tracking state; color index 8 and strong green after reset.
// ----------------------------------------------------------------------------
module temperature_trend_led_color_dimmer_top #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          button_pressed_i,
  input  logic                          sample_valid_i,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    led_bits_o,
  output logic                          start_conversion_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [ttlcd_pkg::CfgDataW-1:0] cfg_data_i
);
  import ttlcd_pkg::*;

  logic [IntervalW-1:0]   interval_cfg_q;
  logic [WeakOnW-1:0]     weak_on_cfg_q;

  logic [SAMPLE_BITS-1:0] ref_q, ref_d;
  logic [SAMPLE_BITS-1:0] latest_q, latest_d;
  logic                   ref_set_q, ref_set_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [2:0]             strong_q, strong_d;
  logic [2:0]             weak_q, weak_d;
  logic [OffW-1:0]        off_q, off_d;
  logic                   dim_on_q, dim_on_d;
  logic [DimCntW-1:0]     dim_cnt_q, dim_cnt_d;
  logic [IntervalW-1:0]   intv_cnt_q, intv_cnt_d;
  logic [2:0]             pins_q, pins_d;

  logic                   out_valid_q;
  logic [2:0]             led_q;
  logic                   start_q, start_d;

  logic                   in_fire;
  logic [SAMPLE_BITS-1:0] ref_btn;
  logic [IdxW-1:0]        idx_btn;
  logic [IntervalW-1:0]   intv_inc;
  logic [DimCntW-1:0]     dim_inc;
  color_entry_t           entry;

  assign in_ready_o         = !out_valid_q || out_ready_i;
  assign in_fire            = in_valid_i && in_ready_o;
  assign out_valid_o        = out_valid_q;
  assign led_bits_o         = led_q;
  assign start_conversion_o = start_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_cfg_q <= IntervalReset;
      weak_on_cfg_q  <= WeakOnReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_SAMPLE_INTERVAL) begin
        interval_cfg_q <= cfg_data_i[IntervalW-1:0];
      end
      if (cfg_index_i == CFG_WEAK_ON) begin
        weak_on_cfg_q <= cfg_data_i[WeakOnW-1:0];
      end
    end
  end

  always_comb begin
    // button first: it rewinds the reference and index before the sample
    ref_btn = button_pressed_i ? latest_q : ref_q;
    idx_btn = button_pressed_i ? HomeIndex : idx_q;
    entry   = color_rom(idx_btn);

    ref_d     = ref_btn;
    idx_d     = idx_btn;
    latest_d  = latest_q;
    ref_set_d = ref_set_q;
    strong_d  = strong_q;
    weak_d    = weak_q;
    off_d     = off_q;

    // conversion start interval
    intv_inc = intv_cnt_q + 1'b1;
    if (intv_inc == interval_cfg_q) begin
      intv_cnt_d = '0;
      start_d    = 1'b1;
    end else begin
      intv_cnt_d = intv_inc;
      start_d    = 1'b0;
    end

    if (sample_valid_i) begin
      latest_d = sample_i;
      if (!ref_set_q) begin
        ref_d     = sample_i;
        ref_set_d = 1'b1;
      end else if (sample_i != ref_btn) begin
        strong_d = entry.strong_col;
        weak_d   = entry.weak_col;
        off_d    = entry.off;
        ref_d    = sample_i;
        if (sample_i > ref_btn) begin
          // warmer: step toward red
          if (idx_btn != '0) begin
            idx_d = idx_btn - 1'b1;
          end
        end else if (idx_btn < LastIndex) begin
          idx_d = idx_btn + 1'b1;
        end
      end
    end

    // weak color PWM
    dim_inc   = dim_cnt_q + 1'b1;
    dim_cnt_d = dim_inc;
    dim_on_d  = dim_on_q;
    pins_d    = pins_q;
    if (dim_on_q) begin
      if (dim_inc == {{(DimCntW-WeakOnW){1'b0}}, weak_on_cfg_q}) begin
        dim_on_d  = 1'b0;
        pins_d    = '0;
        dim_cnt_d = '0;
      end
    end else if (dim_inc == {{(DimCntW-OffW){1'b0}}, off_d} || off_d == '0) begin
      dim_on_d  = 1'b1;
      pins_d    = pins_q | weak_d;
      dim_cnt_d = '0;
    end
    pins_d = pins_d | strong_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= '0;
      latest_q    <= '0;
      ref_set_q   <= 1'b0;
      idx_q       <= HomeIndex;
      strong_q    <= ColorG;
      weak_q      <= '0;
      off_q       <= '0;
      dim_on_q    <= 1'b0;
      dim_cnt_q   <= '0;
      intv_cnt_q  <= '0;
      pins_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        ref_q      <= ref_d;
        latest_q   <= latest_d;
        ref_set_q  <= ref_set_d;
        idx_q      <= idx_d;
        strong_q   <= strong_d;
        weak_q     <= weak_d;
        off_q      <= off_d;
        dim_on_q   <= dim_on_d;
        dim_cnt_q  <= dim_cnt_d;
        intv_cnt_q <= intv_cnt_d;
        pins_q     <= pins_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      led_q   <= pins_d;
      start_q <= start_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIndex)
    else $error("color index out of range");

  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick produced no result");

  a_strong_lit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((led_q & strong_q) == strong_q))
    else $error("strong color not lit in result");

  a_ref_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_set_q |=> ref_set_q)
    else $error("reference flag cleared");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives scheduler ticks into the temperature trend LED color dimmer under
// several sender/receiver idling mixes and register settings. A local
// predictor tracks the trend index, color latch, dimming counters and the
// conversion interval, and each result transfer is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttlcd_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  localparam logic [2:0] StrongTbl [20] = '{
    ColorR, ColorR, ColorR, ColorR, ColorR | ColorG,
    ColorG, ColorG, ColorG, ColorG, ColorG,
    ColorG, ColorG, ColorG | ColorB, ColorB, ColorB,
    ColorB, ColorB, ColorB, ColorB, ColorB};
  localparam logic [2:0] WeakTbl [20] = '{
    3'b000, ColorG, ColorG, ColorG, 3'b000,
    ColorR, ColorR, ColorR, 3'b000, ColorB,
    ColorB, ColorB, 3'b000, ColorG, ColorG,
    ColorG, 3'b000, ColorR, ColorR, ColorR};
  localparam logic [OffW-1:0] OffTbl [20] = '{
    4'd0, 4'd9, 4'd3, 4'd1, 4'd0, 4'd1, 4'd3, 4'd9, 4'd0, 4'd9,
    4'd3, 4'd1, 4'd0, 4'd1, 4'd3, 4'd9, 4'd0, 4'd9, 4'd3, 4'd1};

  typedef struct packed {
    logic [2:0] led;
    logic       conv;
  } tick_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                button_pressed_i = 1'b0;
  logic                sample_valid_i = 1'b0;
  logic [9:0]          sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          led_bits_o;
  logic                start_conversion_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  temperature_trend_led_color_dimmer_top #(
    .SAMPLE_BITS(10)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .button_pressed_i  (button_pressed_i),
    .sample_valid_i    (sample_valid_i),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .led_bits_o        (led_bits_o),
    .start_conversion_o(start_conversion_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state
  logic [IntervalW-1:0] interval_cfg;
  logic [WeakOnW-1:0]   weak_on_cfg;
  logic [9:0]           ref_temp;
  logic [9:0]           last_temp;
  logic                 ref_known;
  logic [IdxW-1:0]      trend_idx;
  logic [2:0]           strong_led;
  logic [2:0]           weak_led;
  logic [OffW-1:0]      off_len;
  logic                 dimming;
  logic [DimCntW-1:0]   dim_cnt;
  logic [IntervalW-1:0] conv_cnt;
  logic [2:0]           lit_pins;

  tick_result_t led_q[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  sender_gap_pct = 0;
  int unsigned  rx_stall_pct = 0;
  bit           tick_held = 1'b0;
  int           walk_temp = 512;
  int           walk_dir = 1;
  int           walk_left = 0;

  task automatic reset_predictor();
    interval_cfg = IntervalReset;
    weak_on_cfg  = WeakOnReset;
    ref_temp     = '0;
    last_temp    = '0;
    ref_known    = 1'b0;
    trend_idx    = HomeIndex;
    strong_led   = ColorG;
    weak_led     = 3'b000;
    off_len      = '0;
    dimming      = 1'b0;
    dim_cnt      = '0;
    conv_cnt     = '0;
    lit_pins     = 3'b000;
  endtask

  task automatic latch_color();
    strong_led = StrongTbl[trend_idx];
    weak_led   = WeakTbl[trend_idx];
    off_len    = OffTbl[trend_idx];
  endtask

  task automatic predict_tick(input logic btn, input logic sv, input logic [9:0] smp,
                              output tick_result_t res);
    res.conv = 1'b0;
    if (btn) begin
      ref_temp  = last_temp;
      trend_idx = HomeIndex;
    end
    conv_cnt = conv_cnt + 1'b1;
    if (conv_cnt == interval_cfg) begin
      conv_cnt = '0;
      res.conv = 1'b1;
    end
    if (sv) begin
      last_temp = smp;
      if (!ref_known) begin
        ref_temp  = smp;
        ref_known = 1'b1;
      end else if (smp > ref_temp) begin
        latch_color();
        if (trend_idx != 0) trend_idx = trend_idx - 1'b1;
        ref_temp = smp;
      end else if (smp < ref_temp) begin
        latch_color();
        if (trend_idx < LastIndex) trend_idx = trend_idx + 1'b1;
        ref_temp = smp;
      end
    end
    dim_cnt = dim_cnt + 1'b1;
    if (dimming) begin
      if (dim_cnt == DimCntW'(weak_on_cfg)) begin
        dimming  = 1'b0;
        lit_pins = 3'b000;
        dim_cnt  = '0;
      end
    end else if (dim_cnt == DimCntW'(off_len) || off_len == 0) begin
      dimming  = 1'b1;
      lit_pins = lit_pins | weak_led;
      dim_cnt  = '0;
    end
    lit_pins = lit_pins | strong_led;
    res.led  = lit_pins;
  endtask

  function automatic void flag_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_results
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (led_q.size() == 0) begin
        flag_mismatch("unexpected result, led_bits", 0, led_bits_o);
      end else begin
        want = led_q.pop_front();
        if (led_bits_o !== want.led) flag_mismatch("led_bits", want.led, led_bits_o);
        if (start_conversion_o !== want.conv)
          flag_mismatch("start_conversion", want.conv, start_conversion_o);
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_tick(input logic btn, input logic sv, input logic [9:0] smp);
    tick_result_t res;
    if ($urandom_range(99) < sender_gap_pct) begin
      if (tick_held) begin
        in_valid_i <= 1'b0;
        tick_held = 1'b0;
      end
      do @(posedge clk_i); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid_i       <= 1'b1;
    button_pressed_i <= btn;
    sample_valid_i   <= sv;
    sample_i         <= smp;
    tick_held = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_tick(btn, sv, smp, res);
    led_q.push_back(res);
  endtask

  task automatic drain_results();
    if (tick_held) begin
      in_valid_i <= 1'b0;
      tick_held = 1'b0;
    end
    while (led_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [IntervalW-1:0] interval, input logic [WeakOnW-1:0] weak_on);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SAMPLE_INTERVAL;
    cfg_data_i  <= CfgDataW'(interval);
    @(posedge clk_i);
    interval_cfg = interval;
    cfg_index_i <= CFG_WEAK_ON;
    cfg_data_i  <= CfgDataW'(weak_on);
    @(posedge clk_i);
    weak_on_cfg = weak_on;
    cfg_we_i <= 1'b0;
  endtask

  // Mostly monotone temperature runs so the index reaches both ends,
  // mixed with holds, out-of-trend noise and button presses.
  task automatic run_trend_ticks(input int count, input int unsigned sample_pct);
    int k;
    logic btn;
    logic sv;
    logic [9:0] smp;
    for (k = 0; k < count; k++) begin
      if (walk_left == 0) begin
        walk_dir  = $urandom_range(1) ? 1 : -1;
        walk_left = $urandom_range(25, 1);
      end
      walk_left--;
      btn = ($urandom_range(99) < 3);
      sv  = ($urandom_range(99) < sample_pct);
      smp = 10'($urandom);
      if (sv) begin
        case ($urandom_range(9))
          0: ;
          1: smp = 10'(walk_temp);
          default: begin
            walk_temp += walk_dir * int'($urandom_range(40, 1));
            if (walk_temp > 1023) begin
              walk_temp = 1023;
              walk_dir  = -1;
            end else if (walk_temp < 0) begin
              walk_temp = 0;
              walk_dir  = 1;
            end
            smp = 10'(walk_temp);
          end
        endcase
      end
      if ($urandom_range(299) == 0) drain_results();
      send_tick(btn, sv, smp);
    end
  endtask

  task automatic test_directed_trend();
    sender_gap_pct = 0;
    rx_stall_pct   = 0;
    send_tick(1'b1, 1'b0, 10'h3FF);   // button before any sample
    send_tick(1'b0, 1'b0, 10'h155);   // sample ignored without its flag
    send_tick(1'b0, 1'b1, 10'd512);   // first sample: reference only
    send_tick(1'b0, 1'b1, 10'd512);   // equal: no change
    send_tick(1'b0, 1'b1, 10'd1023);  // warmer
    send_tick(1'b0, 1'b1, 10'd0);     // cooler
    send_tick(1'b0, 1'b1, 10'd0);
    send_tick(1'b1, 1'b1, 10'd700);   // button and sample on one tick
    send_tick(1'b1, 1'b0, 10'd0);
    send_tick(1'b0, 1'b1, 10'h2AA);
    send_tick(1'b0, 1'b1, 10'h155);
    send_tick(1'b0, 1'b1, 10'h3FF);
    repeat (8) send_tick(1'b0, 1'b0, 10'h000);
    drain_results();
  endtask

  task automatic test_no_idle();
    set_config(12'd1, 8'd255);
    sender_gap_pct = 0;
    rx_stall_pct   = 0;
    run_trend_ticks(350, 60);
  endtask

  task automatic test_sender_gaps();
    set_config(12'd4095, 8'd1);
    sender_gap_pct = 74;
    rx_stall_pct   = 0;
    run_trend_ticks(350, 60);
  endtask

  task automatic test_receiver_stalls();
    set_config(12'd9, 8'd37);
    sender_gap_pct = 0;
    rx_stall_pct   = 74;
    run_trend_ticks(350, 60);
  endtask

  task automatic test_both_idle();
    set_config(12'd3, 8'd2);
    sender_gap_pct = 13;
    rx_stall_pct   = 13;
    run_trend_ticks(350, 60);
  endtask

  // Zero registers: no conversion pulse before the counter wraps and the
  // weak color stays on. Then an interval below the running count.
  task automatic test_counter_wraps();
    set_config(12'd0, 8'd0);
    sender_gap_pct = 0;
    rx_stall_pct   = 0;
    run_trend_ticks(250, 20);
    set_config(12'd20, 8'd5);
    run_trend_ticks(250, 20);
  endtask

  initial begin
    reset_predictor();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_trend();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_counter_wraps();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (led_q.size() != 0) flag_mismatch("results missing", 0, led_q.size());
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
